FILE: rtl/ipmc_pkg.sv
// shared types and constants of the idle power mode controller
package ipmc_pkg;

	// width of the timeout registers and of the ticks_left field
	localparam int unsigned TIMEOUT_W = 16;
	// timeout held by both registers and by the counter after reset
	localparam logic [TIMEOUT_W-1:0] RESET_TICKS = 16'd10;
	// entries of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// event codes of the sensor messages
	localparam logic [7:0] CHAR_UP_M = 8'h4D;
	localparam logic [7:0] CHAR_LO_M = 8'h6D;
	localparam logic [7:0] CHAR_UP_L = 8'h4C;
	localparam logic [7:0] CHAR_LO_L = 8'h6C;
	localparam logic [7:0] CHAR_UP_S = 8'h53;
	localparam logic [7:0] CHAR_UP_B = 8'h42;
	localparam logic [7:0] CHAR_UP_P = 8'h50;
	localparam logic [7:0] CHAR_UP_O = 8'h4F;

	// item kinds
	localparam logic KIND_MESSAGE = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_FULL_TO_SLEEP  = 1'b0;
	localparam logic [0:0] REG_SLEEP_TO_HIBER = 1'b1;

	typedef enum logic [1:0] {
		MODE_FULL  = 2'd0,
		MODE_SLEEP = 2'd1,
		MODE_HIBER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_KEEP   = 2'd0,
		CMD_STOP   = 2'd1,
		CMD_RELOAD = 2'd2
	} cmd_t;

	// item class decided by the front end
	typedef enum logic [2:0] {
		CLS_TICK       = 3'd0,
		CLS_TOGGLE     = 3'd1,
		CLS_MOTION_ON  = 3'd2,
		CLS_MOTION_OFF = 3'd3,
		CLS_WAKE       = 3'd4,
		CLS_NONE       = 3'd5
	} msg_class_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] message_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           active_mode;
		logic                 mode_changed;
		logic                 timeout_fired;
		logic                 timer_armed;
		logic [TIMEOUT_W-1:0] ticks_left;
		logic                 motion_active;
	} out_item_t;

	typedef struct packed {
		logic [0:0]           reg_index;
		logic [TIMEOUT_W-1:0] wdata;
	} cfg_write_t;

	// push from the front end into the queue
	typedef struct packed {
		logic       valid;
		msg_class_t cls;
	} queue_push_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic       valid;
		msg_class_t cls;
	} queue_head_t;

endpackage

FILE: rtl/ipmc_stream_if.sv
// valid/ready channel carrying one item of a given payload type
interface ipmc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ipmc_front.sv
// front end: accepts items and classifies them for the back end
module ipmc_front (
	ipmc_stream_if.sink           item,
	input  logic                  queue_full,
	output ipmc_pkg::queue_push_t push
);

	ipmc_pkg::msg_class_t cls;

	// decode the message byte into its class
	always_comb begin
		if (item.data.kind == ipmc_pkg::KIND_TICK) begin
			cls = ipmc_pkg::CLS_TICK;
		end else begin
			case (item.data.message_byte)
				ipmc_pkg::CHAR_UP_B,
				ipmc_pkg::CHAR_UP_P: cls = ipmc_pkg::CLS_TOGGLE;
				ipmc_pkg::CHAR_UP_M: cls = ipmc_pkg::CLS_MOTION_ON;
				ipmc_pkg::CHAR_LO_M: cls = ipmc_pkg::CLS_MOTION_OFF;
				ipmc_pkg::CHAR_UP_L,
				ipmc_pkg::CHAR_LO_L,
				ipmc_pkg::CHAR_UP_S,
				ipmc_pkg::CHAR_UP_O: cls = ipmc_pkg::CLS_WAKE;
				default:             cls = ipmc_pkg::CLS_NONE;
			endcase
		end
	end

	// take an item whenever the queue has room
	assign item.ready = !queue_full;
	assign push.valid = item.valid && !queue_full;
	assign push.cls   = cls;

endmodule

FILE: rtl/ipmc_queue.sv
// short queue of classified items between front and back end
module ipmc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipmc_pkg::queue_push_t push,
	output logic                  full,
	input  logic                  pop,
	output ipmc_pkg::queue_head_t head
);

	localparam int unsigned PTR_W = ipmc_pkg::QUEUE_PTR_W;
	localparam int unsigned CNT_W = $clog2(ipmc_pkg::QUEUE_DEPTH + 1);

	ipmc_pkg::msg_class_t entry_q [ipmc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CNT_W'(ipmc_pkg::QUEUE_DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cls   = entry_q[rd_ptr_q];

	// pointer wrap helper
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(ipmc_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cls;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/ipmc_back.sv
// back end: mode, motion, timer command and idle timer, plus result register
module ipmc_back #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipmc_pkg::queue_head_t head,
	output logic                  pop,
	ipmc_stream_if.sink           cfg,
	ipmc_stream_if.source         result
);

	localparam int unsigned TW = ipmc_pkg::TIMEOUT_W;
	localparam logic [32:0] CNT_MAX = (33'd1 << TIMER_BITS) - 33'd1;

	logic [TW-1:0]         full_to_sleep_q;
	logic [TW-1:0]         sleep_to_hiber_q;
	ipmc_pkg::mode_t       mode_q;
	logic                  motion_q;
	ipmc_pkg::cmd_t        cmd_q;
	logic                  armed_q;
	logic [TIMER_BITS-1:0] count_q;
	logic                  out_valid_q;
	ipmc_pkg::out_item_t   out_data_q;

	ipmc_pkg::mode_t       mode_n;
	logic                  motion_n;
	ipmc_pkg::cmd_t        cmd_n;
	logic                  armed_n;
	logic [TIMER_BITS-1:0] count_n;
	logic                  fired;
	logic [TW-1:0]         reload_val;

	// clamp a timeout to the counter range
	function automatic logic [TIMER_BITS-1:0] clamp(input logic [TW-1:0] t);
		if (33'(t) > CNT_MAX) begin
			return '1;
		end
		return TIMER_BITS'(t);
	endfunction

	// timeout belonging to a mode
	function automatic logic [TW-1:0] timeout_of(input ipmc_pkg::mode_t m,
		input logic [TW-1:0] t_full, input logic [TW-1:0] t_sleep);
		case (m)
			ipmc_pkg::MODE_FULL:  return t_full;
			ipmc_pkg::MODE_SLEEP: return t_sleep;
			default:              return '0;
		endcase
	endfunction

	// configuration registers, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_to_sleep_q  <= ipmc_pkg::RESET_TICKS;
			sleep_to_hiber_q <= ipmc_pkg::RESET_TICKS;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				ipmc_pkg::REG_FULL_TO_SLEEP:  full_to_sleep_q  <= cfg.data.wdata;
				ipmc_pkg::REG_SLEEP_TO_HIBER: sleep_to_hiber_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// next state for the item at the queue head
	always_comb begin
		mode_n     = mode_q;
		motion_n   = motion_q;
		cmd_n      = cmd_q;
		armed_n    = armed_q;
		count_n    = count_q;
		fired      = 1'b0;
		reload_val = '0;
		if (head.cls != ipmc_pkg::CLS_TICK) begin
			// message table, skipped in an unknown mode
			if (mode_q inside {ipmc_pkg::MODE_FULL, ipmc_pkg::MODE_SLEEP,
				ipmc_pkg::MODE_HIBER}) begin
				case (head.cls)
					ipmc_pkg::CLS_TOGGLE: begin
						mode_n = (mode_q == ipmc_pkg::MODE_FULL) ? ipmc_pkg::MODE_SLEEP
							: ipmc_pkg::MODE_FULL;
						cmd_n  = ipmc_pkg::CMD_RELOAD;
					end
					ipmc_pkg::CLS_MOTION_ON: begin
						motion_n = 1'b1;
						cmd_n    = ipmc_pkg::CMD_STOP;
						if (mode_q == ipmc_pkg::MODE_HIBER) begin
							mode_n = ipmc_pkg::MODE_SLEEP;
						end
					end
					ipmc_pkg::CLS_MOTION_OFF: begin
						motion_n = 1'b0;
						cmd_n    = ipmc_pkg::CMD_RELOAD;
						if (mode_q == ipmc_pkg::MODE_HIBER) begin
							mode_n = ipmc_pkg::MODE_SLEEP;
						end
					end
					ipmc_pkg::CLS_WAKE: begin
						cmd_n = ipmc_pkg::CMD_RELOAD;
						if (mode_q == ipmc_pkg::MODE_HIBER) begin
							mode_n = ipmc_pkg::MODE_SLEEP;
						end
					end
					default: ;
				endcase
			end
			// sticky command applied after every message
			if (cmd_n != ipmc_pkg::CMD_KEEP) begin
				armed_n = 1'b0;
				count_n = '0;
				if (cmd_n == ipmc_pkg::CMD_RELOAD) begin
					reload_val = timeout_of(mode_n, full_to_sleep_q, sleep_to_hiber_q);
					armed_n    = (reload_val != '0);
					count_n    = clamp(reload_val);
				end
			end
		end else if (armed_q) begin
			// count down, expiry may drop the mode
			count_n = (count_q != '0) ? count_q - TIMER_BITS'(1) : '0;
			if (count_n == '0) begin
				fired   = 1'b1;
				armed_n = 1'b0;
				if (!motion_q) begin
					case (mode_q)
						ipmc_pkg::MODE_FULL: begin
							mode_n     = ipmc_pkg::MODE_SLEEP;
							reload_val = sleep_to_hiber_q;
							armed_n    = (reload_val != '0);
							count_n    = clamp(reload_val);
						end
						ipmc_pkg::MODE_SLEEP: mode_n = ipmc_pkg::MODE_HIBER;
						default: ;
					endcase
				end
			end
		end
	end

	// take the head whenever the result register is free or drains
	assign pop = head.valid && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// controller state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ipmc_pkg::MODE_SLEEP;
			motion_q    <= 1'b1;
			cmd_q       <= ipmc_pkg::CMD_KEEP;
			armed_q     <= 1'b1;
			count_q     <= TIMER_BITS'(ipmc_pkg::RESET_TICKS);
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_n;
				motion_q    <= motion_n;
				cmd_q       <= cmd_n;
				armed_q     <= armed_n;
				count_q     <= count_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.active_mode   <= mode_n;
			out_data_q.mode_changed  <= (mode_n != mode_q);
			out_data_q.timeout_fired <= fired;
			out_data_q.timer_armed   <= armed_n;
			out_data_q.ticks_left    <= armed_n ? TW'(count_n) : '0;
			out_data_q.motion_active <= motion_n;
		end
	end

endmodule

FILE: rtl/idle_power_mode_controller.sv
// top level of the idle power mode controller
// Takes one item per clock cycle while the queue has room (a sensor message
// byte or a one-second tick) and returns exactly one result per item, via the
// queue entry and then the result register. The front end classifies
// each message byte and writes it into a two-entry queue; the back end
// applies one item per cycle, while the result register is free or drains, to
// the mode, motion flag, sticky timer command and idle counter; its state
// update sets the rate. The queue lets a new item enter while the
// previous result is still waiting. The two timeout registers are written
// through the cfg channel, which is always ready; write them only while the
// block is idle. TIMER_BITS sets the width of the idle counter, and
// timeouts above its range are clamped to the counter maximum.
module idle_power_mode_controller #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ipmc_stream_if.sink   item,
	ipmc_stream_if.sink   cfg,
	ipmc_stream_if.source result
);

	ipmc_pkg::queue_push_t push;
	ipmc_pkg::queue_head_t head;
	logic                  queue_full;
	logic                  pop;

	// item intake and classification
	ipmc_front u_front (
		.item       (item),
		.queue_full (queue_full),
		.push       (push)
	);

	// decoupling queue
	ipmc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	// state update and result stage
	ipmc_back #(
		.TIMER_BITS (TIMER_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg),
		.result (result)
	);

endmodule

FILE: bench/tb_idle_power_mode_controller.sv
// testbench of the idle power mode controller: random and directed items checked against a predictor
`timescale 1ns / 100ps

module tb_idle_power_mode_controller;

	// byte that the block treats like an unknown code
	localparam logic [7:0] CHAR_LO_S = 8'h73;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 105;
	localparam int unsigned LONG_HOLD_CYCLES = 100;
	localparam int unsigned QUIET_LIMIT = 1000;

	logic clk;
	logic arst_n;

	ipmc_stream_if #(.payload_t(ipmc_pkg::in_item_t))   item_if ();
	ipmc_stream_if #(.payload_t(ipmc_pkg::cfg_write_t)) cfg_if ();
	ipmc_stream_if #(.payload_t(ipmc_pkg::out_item_t))  result_if ();

	idle_power_mode_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.cfg(cfg_if),
		.result(result_if)
	);

	// predicted controller state and timeout registers
	ipmc_pkg::mode_t     ctl_mode;
	logic                ctl_motion;
	ipmc_pkg::cmd_t      ctl_cmd;
	logic                ctl_armed;
	logic [15:0]         ctl_count;
	logic [15:0]         full_ticks_reg;
	logic [15:0]         sleep_ticks_reg;

	ipmc_pkg::out_item_t expected_reports[$];
	ipmc_pkg::in_item_t  pending_items[$];
	ipmc_pkg::out_item_t want;
	logic [7:0]          event_codes[10];
	logic [15:0]         full_plan[RANDOM_PHASES];
	logic [15:0]         sleep_plan[RANDOM_PHASES];

	int unsigned items_queued;
	int unsigned items_accepted;
	int unsigned cfg_writes_seen;
	int unsigned failures;
	int unsigned quiet_cycles;
	int unsigned send_gap;
	int unsigned hold_off_left;
	bit          item_fired;
	bit          pauses_on;
	bit          long_hold_req;

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned pick_pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] timeout_of(ipmc_pkg::mode_t m);
		case (m)
			ipmc_pkg::MODE_FULL:  return full_ticks_reg;
			ipmc_pkg::MODE_SLEEP: return sleep_ticks_reg;
			default:              return '0;
		endcase
	endfunction

	// zero timeout leaves the timer disarmed
	function automatic void load_idle_timer(logic [15:0] t);
		ctl_armed = (t != '0);
		ctl_count = t;
	endfunction

	// apply one item to the predicted state and return the expected result
	function automatic ipmc_pkg::out_item_t advance_controller(ipmc_pkg::in_item_t it);
		ipmc_pkg::mode_t     prior;
		logic                was_hiber;
		logic                fired;
		ipmc_pkg::out_item_t r;
		prior = ctl_mode;
		was_hiber = (ctl_mode == ipmc_pkg::MODE_HIBER);
		fired = 1'b0;
		if (it.kind == ipmc_pkg::KIND_MESSAGE) begin
			case (it.message_byte)
				ipmc_pkg::CHAR_UP_B, ipmc_pkg::CHAR_UP_P: begin
					ctl_mode = (ctl_mode == ipmc_pkg::MODE_FULL) ? ipmc_pkg::MODE_SLEEP
						: ipmc_pkg::MODE_FULL;
					ctl_cmd = ipmc_pkg::CMD_RELOAD;
				end
				ipmc_pkg::CHAR_UP_M: begin
					ctl_motion = 1'b1;
					ctl_cmd = ipmc_pkg::CMD_STOP;
					if (was_hiber)
						ctl_mode = ipmc_pkg::MODE_SLEEP;
				end
				ipmc_pkg::CHAR_LO_M: begin
					ctl_motion = 1'b0;
					ctl_cmd = ipmc_pkg::CMD_RELOAD;
					if (was_hiber)
						ctl_mode = ipmc_pkg::MODE_SLEEP;
				end
				ipmc_pkg::CHAR_UP_L, ipmc_pkg::CHAR_LO_L, ipmc_pkg::CHAR_UP_S,
				ipmc_pkg::CHAR_UP_O: begin
					ctl_cmd = ipmc_pkg::CMD_RELOAD;
					if (was_hiber)
						ctl_mode = ipmc_pkg::MODE_SLEEP;
				end
				default: begin
				end
			endcase
			// sticky command is applied after every message
			if (ctl_cmd == ipmc_pkg::CMD_RELOAD) begin
				load_idle_timer(timeout_of(ctl_mode));
			end else if (ctl_cmd != ipmc_pkg::CMD_KEEP) begin
				ctl_armed = 1'b0;
				ctl_count = '0;
			end
		end else if (ctl_armed) begin
			if (ctl_count != '0)
				ctl_count = ctl_count - 16'd1;
			if (ctl_count == '0) begin
				fired = 1'b1;
				ctl_armed = 1'b0;
				if (!ctl_motion) begin
					if (ctl_mode == ipmc_pkg::MODE_FULL) begin
						ctl_mode = ipmc_pkg::MODE_SLEEP;
						load_idle_timer(timeout_of(ipmc_pkg::MODE_SLEEP));
					end else if (ctl_mode == ipmc_pkg::MODE_SLEEP) begin
						ctl_mode = ipmc_pkg::MODE_HIBER;
					end
				end
			end
		end
		r.active_mode = ctl_mode;
		r.mode_changed = (ctl_mode != prior);
		r.timeout_fired = fired;
		r.timer_armed = ctl_armed;
		r.ticks_left = ctl_armed ? ctl_count : '0;
		r.motion_active = ctl_motion;
		return r;
	endfunction

	function automatic void check_field(string field, longint unsigned exp_val,
			longint unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			failures++;
		end
	endfunction

	// item driver, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_if.valid && !item_fired) begin
				// item still offered
			end else if (send_gap > 0) begin
				send_gap--;
				item_if.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item_if.data <= pending_items.pop_front();
				item_if.valid <= 1'b1;
				send_gap = pauses_on ? pick_pause_len() : 0;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, including the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_if.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_off_left = LONG_HOLD_CYCLES - 1;
				result_if.ready <= 1'b0;
			end else if (pauses_on && $urandom_range(0, 3) == 0) begin
				hold_off_left = pick_pause_len();
				if (hold_off_left > 0) begin
					hold_off_left--;
					result_if.ready <= 1'b0;
				end else begin
					result_if.ready <= 1'b1;
				end
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted items, check results, watchdog
	always @(posedge clk) begin
		item_fired = item_if.valid && item_if.ready;
		if (item_fired) begin
			expected_reports.push_back(advance_controller(item_if.data));
			items_accepted++;
		end
		if (cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.data.reg_index)
				ipmc_pkg::REG_FULL_TO_SLEEP:  full_ticks_reg = cfg_if.data.wdata;
				ipmc_pkg::REG_SLEEP_TO_HIBER: sleep_ticks_reg = cfg_if.data.wdata;
				default: begin
				end
			endcase
			cfg_writes_seen++;
		end
		if (result_if.valid && result_if.ready) begin
			if (expected_reports.size() == 0) begin
				$error("result with no item waiting for it");
				failures++;
			end else begin
				want = expected_reports.pop_front();
				check_field("active_mode", want.active_mode, result_if.data.active_mode);
				check_field("mode_changed", want.mode_changed, result_if.data.mode_changed);
				check_field("timeout_fired", want.timeout_fired, result_if.data.timeout_fired);
				check_field("timer_armed", want.timer_armed, result_if.data.timer_armed);
				check_field("ticks_left", want.ticks_left, result_if.data.ticks_left);
				check_field("motion_active", want.motion_active,
					result_if.data.motion_active);
			end
		end
		if (item_fired || (cfg_if.valid && cfg_if.ready) ||
				(result_if.valid && result_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic queue_item(input logic kind, input logic [7:0] code);
		pending_items.push_back(ipmc_pkg::in_item_t'{kind: kind, message_byte: code});
		items_queued++;
	endtask

	// all queued items accepted and all results checked
	task automatic wait_drained();
		while (items_accepted != items_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [0:0] idx, input logic [15:0] val);
		int unsigned target;
		target = cfg_writes_seen + 1;
		@(negedge clk);
		cfg_if.data <= ipmc_pkg::cfg_write_t'{reg_index: idx, wdata: val};
		cfg_if.valid <= 1'b1;
		while (cfg_writes_seen < target)
			@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned r;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
		ctl_mode = ipmc_pkg::MODE_SLEEP;
		ctl_motion = 1'b1;
		ctl_cmd = ipmc_pkg::CMD_KEEP;
		ctl_armed = 1'b1;
		ctl_count = ipmc_pkg::RESET_TICKS;
		full_ticks_reg = ipmc_pkg::RESET_TICKS;
		sleep_ticks_reg = ipmc_pkg::RESET_TICKS;
		items_queued = 0;
		items_accepted = 0;
		cfg_writes_seen = 0;
		failures = 0;
		quiet_cycles = 0;
		send_gap = 0;
		hold_off_left = 0;
		item_fired = 1'b0;
		pauses_on = 1'b1;
		long_hold_req = 1'b0;
		event_codes = '{ipmc_pkg::CHAR_UP_B, ipmc_pkg::CHAR_UP_P, ipmc_pkg::CHAR_UP_M,
			ipmc_pkg::CHAR_LO_M, ipmc_pkg::CHAR_LO_M, ipmc_pkg::CHAR_UP_L,
			ipmc_pkg::CHAR_LO_L, ipmc_pkg::CHAR_UP_S, CHAR_LO_S, ipmc_pkg::CHAR_UP_O};
		full_plan = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd6, 16'd0, 16'd2, 16'd0};
		sleep_plan = '{16'd5, 16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd0, 16'd7, 16'd0};
		full_plan[RANDOM_PHASES-1] = 16'($urandom_range(0, 16'hFFFF));
		sleep_plan[RANDOM_PHASES-1] = 16'($urandom_range(0, 16'hFFFF));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset state: tick, unknown extremes, lower-case s, motion on
		queue_item(ipmc_pkg::KIND_TICK, 8'hFF);
		queue_item(ipmc_pkg::KIND_MESSAGE, 8'h00);
		queue_item(ipmc_pkg::KIND_MESSAGE, 8'hFF);
		queue_item(ipmc_pkg::KIND_MESSAGE, CHAR_LO_S);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_M);
		queue_item(ipmc_pkg::KIND_TICK, 8'h00);
		wait_drained();

		// short timeouts: expiry in full and sleep mode, sticky commands, wake-ups
		write_timeout(ipmc_pkg::REG_FULL_TO_SLEEP, 16'd3);
		write_timeout(ipmc_pkg::REG_SLEEP_TO_HIBER, 16'd2);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_B);
		repeat (3) queue_item(ipmc_pkg::KIND_TICK, 8'h00);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_M);
		queue_item(ipmc_pkg::KIND_MESSAGE, 8'h41);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_LO_M);
		queue_item(ipmc_pkg::KIND_TICK, 8'h00);
		queue_item(ipmc_pkg::KIND_MESSAGE, 8'h20);
		repeat (3) queue_item(ipmc_pkg::KIND_TICK, 8'h00);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_P);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_S);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_L);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_B);
		repeat (2) queue_item(ipmc_pkg::KIND_TICK, 8'h00);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_UP_O);
		queue_item(ipmc_pkg::KIND_MESSAGE, ipmc_pkg::CHAR_LO_L);
		wait_drained();

		// random phases over several timeout settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_timeout(ipmc_pkg::REG_FULL_TO_SLEEP, full_plan[p]);
			write_timeout(ipmc_pkg::REG_SLEEP_TO_HIBER, sleep_plan[p]);
			pauses_on = (p % 2 == 1) || (p == 2);
			if (p == 2)
				long_hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					queue_item(ipmc_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
				else if (r < 62)
					queue_item(ipmc_pkg::KIND_MESSAGE, 8'($urandom_range(0, 255)));
				else
					queue_item(ipmc_pkg::KIND_MESSAGE, event_codes[$urandom_range(0, 9)]);
			end
			wait_drained();
		end

		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: idle_power_mode_controller.f
rtl/ipmc_pkg.sv
rtl/ipmc_stream_if.sv
rtl/ipmc_front.sv
rtl/ipmc_queue.sv
rtl/ipmc_back.sv
rtl/idle_power_mode_controller.sv
bench/tb_idle_power_mode_controller.sv
